// ===== rtl/cxo_pkg.sv =====
`timescale 1ns / 1ps

package cxo_pkg;

  // command codes carried in tuser of the input stream
  typedef enum logic [2:0] {
    CMD_PIXEL    = 3'd0,
    CMD_LOAD_ROW = 3'd1,
    CMD_SET_POS  = 3'd2,
    CMD_SET_HOT  = 3'd3,
    CMD_ENABLE   = 3'd4,
    CMD_DISABLE  = 3'd5,
    CMD_HIDE     = 3'd6,
    CMD_UNHIDE   = 3'd7
  } cmd_t;

  // register indexes of the configuration port
  localparam logic REG_LOG_DEPTH = 1'b0;

  localparam int unsigned LOG_DEPTH_RESET = 3;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned PLANE_W         = 16;
  localparam int unsigned HIDE_MAX        = 255;

  // and mask per cursor code: transparent, white, black, invert
  function automatic logic [7:0] ovl_and(input logic [1:0] n);
    logic [7:0] m;
    case (n)
      2'd0:    m = 8'hFF;
      2'd1:    m = 8'h00;
      2'd2:    m = 8'h00;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // xor datum per cursor code
  function automatic logic [7:0] ovl_xor(input logic [1:0] n);
    logic [7:0] d;
    case (n)
      2'd0:    d = 8'h00;
      2'd1:    d = 8'hFF;
      2'd2:    d = 8'h00;
      default: d = 8'hFF;
    endcase
    return d;
  endfunction

  // pixel depth mask from log2 of bits per pixel
  function automatic logic [7:0] depth_mask(input logic [1:0] ld);
    logic [7:0] m;
    case (ld)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/cursor_and_xor_overlay_top.sv =====
// a pixel accepted at the input passes through the stage 1 and stage 2 registers into the
// output register, from which its output transfer can complete
// throughput: one item per cycle; the three stages advance together whenever the
// output register is empty or its transfer completes
// command items produce no output and leave a bubble in the stream
// reset (rst, synchronous, active high) empties the pipeline, clears the cursor
`timescale 1ns / 1ps

module cursor_and_xor_overlay_top #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // coord_x, coord_y, pixel_in, row_index, clear_bits, set_bits, hot_x, hot_y
  input  logic [79:0] s_tdata,
  // cmd
  input  logic [2:0]  s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_out
  output logic [7:0]  m_tdata,
  // in_cursor
  output logic        m_tuser,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // image, position, hotspot, enable and hide count, and sets log_depth to 3
  localparam int IDX_W = (CURSOR_SIZE > 1) ? $clog2(CURSOR_SIZE) : 1;
  localparam int D_W   = 15;

  // input fields
  cxo_pkg::cmd_t    in_cmd;
  logic [11:0]      in_x;
  logic [11:0]      in_y;
  logic [7:0]       in_pix;
  logic [3:0]       in_row;
  logic [15:0]      in_clr;
  logic [15:0]      in_set;
  logic [5:0]       in_hot_x;
  logic [5:0]       in_hot_y;

  assign in_cmd   = cxo_pkg::cmd_t'(s_tuser);
  assign in_x     = s_tdata[11:0];
  assign in_y     = s_tdata[23:12];
  assign in_pix   = s_tdata[31:24];
  assign in_row   = s_tdata[35:32];
  assign in_clr   = s_tdata[51:36];
  assign in_set   = s_tdata[67:52];
  assign in_hot_x = s_tdata[73:68];
  assign in_hot_y = s_tdata[79:74];

  // cursor state
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [5:0]  hotspot_x;
  logic [5:0]  hotspot_y;
  logic        enabled;
  logic [7:0]  hide_count;
  logic [1:0]  log_depth;
  logic [31:0] cursor_rows [CURSOR_SIZE];

  // stage 1 registers
  logic              s1_valid;
  cxo_pkg::cmd_t     s1_cmd;
  logic [D_W-1:0]    s1_dx;
  logic [D_W-1:0]    s1_dy;
  logic [7:0]        s1_pix;
  logic              s1_vis;
  logic [3:0]        s1_row;
  logic [31:0]       s1_bits;

  // stage 2 registers
  logic        s2_valid;
  logic        s2_hit;
  logic [1:0]  s2_n;
  logic [7:0]  s2_pix;

  logic        adv;
  logic        in_xfer;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign in_xfer  = s_tvalid && s_tready;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cxo_pkg::REG_LOG_DEPTH) ? {30'd0, log_depth} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_depth <= 2'(cxo_pkg::LOG_DEPTH_RESET);
    end else if (cfg_wr && paddr[2] == cxo_pkg::REG_LOG_DEPTH) begin
      log_depth <= pwdata[1:0];
    end
  end

  // box offsets of the incoming pixel: coord - (position - hotspot)
  logic [D_W-1:0] dx_next;
  logic [D_W-1:0] dy_next;
  assign dx_next = {3'd0, in_x} - {3'd0, cursor_x} + {{(D_W-6){hotspot_x[5]}}, hotspot_x};
  assign dy_next = {3'd0, in_y} - {3'd0, cursor_y} + {{(D_W-6){hotspot_y[5]}}, hotspot_y};

  // control commands take effect at the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      hotspot_x  <= '0;
      hotspot_y  <= '0;
      enabled    <= 1'b0;
      hide_count <= '0;
    end else if (in_xfer) begin
      case (in_cmd)
        cxo_pkg::CMD_SET_POS: begin
          cursor_x <= in_x;
          cursor_y <= in_y;
        end
        cxo_pkg::CMD_SET_HOT: begin
          hotspot_x <= in_hot_x;
          hotspot_y <= in_hot_y;
        end
        cxo_pkg::CMD_ENABLE:  enabled <= 1'b1;
        cxo_pkg::CMD_DISABLE: enabled <= 1'b0;
        cxo_pkg::CMD_HIDE: begin
          if (hide_count != 8'(cxo_pkg::HIDE_MAX)) hide_count <= hide_count + 8'd1;
        end
        cxo_pkg::CMD_UNHIDE: begin
          if (hide_count != 8'd0) hide_count <= hide_count - 8'd1;
        end
        default: ;
      endcase
    end
  end

  // stage 1: capture item and box offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= in_cmd;
      s1_dx   <= dx_next;
      s1_dy   <= dy_next;
      s1_pix  <= in_pix;
      s1_vis  <= enabled && (hide_count == 8'd0);
      s1_row  <= in_row;
      s1_bits <= {in_clr, in_set};
    end
  end

  // row loads are written in stream order with the stage 2 row reads
  logic [5:0]       wr_row_ext;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  assign wr_row_ext = {2'd0, s1_row};
  assign wr_idx     = wr_row_ext[IDX_W-1:0];
  assign wr_en      = adv && s1_valid && (s1_cmd == cxo_pkg::CMD_LOAD_ROW)
                      && (wr_row_ext < 6'(CURSOR_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CURSOR_SIZE; i++) cursor_rows[i] <= '0;
    end else if (wr_en) begin
      cursor_rows[wr_idx] <= s1_bits;
    end
  end

  // stage 2: box test, row read and column select
  logic                in_box;
  logic [IDX_W-1:0]    rd_idx;
  logic [31:0]         rd_row;
  logic [15:0]         clr_plane;
  logic [15:0]         set_plane;
  logic [3:0]          col;
  logic [1:0]          n_next;

  assign in_box = s1_vis && !s1_dx[D_W-1] && !s1_dy[D_W-1]
                  && (s1_dx < D_W'(CURSOR_SIZE)) && (s1_dy < D_W'(CURSOR_SIZE));
  assign rd_idx    = s1_dy[IDX_W-1:0];
  assign rd_row    = in_box ? cursor_rows[rd_idx] : 32'd0;
  assign clr_plane = rd_row[2*cxo_pkg::PLANE_W-1:cxo_pkg::PLANE_W];
  assign set_plane = rd_row[cxo_pkg::PLANE_W-1:0];
  assign col       = 4'd15 - s1_dx[3:0];

  always_comb begin
    n_next = 2'd0;
    if (in_box && (s1_dx[D_W-1:4] == '0)) begin
      n_next = {clr_plane[col], set_plane[col]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_cmd == cxo_pkg::CMD_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hit <= in_box;
      s2_n   <= n_next;
      s2_pix <= s1_pix;
    end
  end

  // stage 3: and/xor overlay and depth mask into the output register
  logic [7:0] pix_next;
  assign pix_next = ((s2_pix & cxo_pkg::ovl_and(s2_n)) ^ cxo_pkg::ovl_xor(s2_n))
                    & cxo_pkg::depth_mask(log_depth);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= pix_next;
      m_tuser <= s2_hit;
    end
  end

endmodule

// ===== rtl/cxo_checker.sv =====
`timescale 1ns / 1ps

module cxo_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser
);

  logic adv;
  logic pix_xfer;
  assign adv      = !m_tvalid || m_tready;
  assign pix_xfer = s_tvalid && s_tready && (s_tuser == cxo_pkg::CMD_PIXEL);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input side is ready exactly when the pipeline can advance
  a_ready: assert property (@(posedge clk) disable iff (rst) s_tready == adv)
    else $error("input ready does not follow output stall");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // when every stage has advanced since a transfer, a result exists only for a pixel
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst, 1) && $past(!rst, 2) && $past(!rst, 3)
     && $past(adv, 1) && $past(adv, 2) && $past(adv, 3))
    |-> (m_tvalid == $past(pix_xfer, 3)))
    else $error("result not matching pixel transfer three cycles earlier");

endmodule

bind cursor_and_xor_overlay_top cxo_checker u_cxo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/tb_cursor_and_xor_overlay_top.sv =====
`timescale 1ns / 1ps

module tb_cursor_and_xor_overlay_top;

  localparam int BOX         = 16;
  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 8;

  // input transfer fields, coord_x in the lowest bits
  typedef struct packed {
    logic [5:0]  hot_y;
    logic [5:0]  hot_x;
    logic [15:0] set_bits;
    logic [15:0] clear_bits;
    logic [3:0]  row_index;
    logic [7:0]  pixel_in;
    logic [11:0] coord_y;
    logic [11:0] coord_x;
  } item_t;

  // cursor state mirror and queue of expected output pixels
  class overlay_scoreboard;
    logic [31:0] rows [BOX];
    logic [11:0] cur_x, cur_y;
    logic [5:0]  spot_x, spot_y;
    bit          shown_en;
    int unsigned hide_cnt;
    logic [1:0]  log_depth;
    logic [7:0]  want_pixel [$];
    logic        want_hit [$];
    int          errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      cur_x     = '0;
      cur_y     = '0;
      spot_x    = '0;
      spot_y    = '0;
      shown_en  = 1'b0;
      hide_cnt  = 0;
      log_depth = 2'(cxo_pkg::LOG_DEPTH_RESET);
      errors    = 0;
    endfunction

    // top-left corner of the box, signed, no wrap
    function int box_left();
      int h;
      h = $signed(spot_x);
      return int'(cur_x) - h;
    endfunction

    function int box_top();
      int h;
      h = $signed(spot_y);
      return int'(cur_y) - h;
    endfunction

    function int pending();
      return want_pixel.size();
    endfunction

    function void note_input(cxo_pkg::cmd_t c, item_t it);
      int         dx, dy, b;
      logic [7:0] res, dmask, amask, xmask;
      logic [31:0] r;
      logic [1:0] n;
      logic       hit;
      case (c)
        cxo_pkg::CMD_PIXEL: begin
          dmask = 8'((1 << (1 << log_depth)) - 1);
          dx    = int'(it.coord_x) - box_left();
          dy    = int'(it.coord_y) - box_top();
          res   = it.pixel_in & dmask;
          hit   = 1'b0;
          if (shown_en && hide_cnt == 0 && dx >= 0 && dx < BOX && dy >= 0 && dy < BOX) begin
            // bit 15 of each plane is the leftmost column
            r     = rows[dy];
            b     = 15 - dx;
            n     = {r[16 + b], r[b]};
            amask = {8{~(n[1] ^ n[0])}};
            xmask = {8{n[0]}};
            res   = ((it.pixel_in & amask) ^ xmask) & dmask;
            hit   = 1'b1;
          end
          want_pixel.push_back(res);
          want_hit.push_back(hit);
        end
        cxo_pkg::CMD_LOAD_ROW: rows[it.row_index] = {it.clear_bits, it.set_bits};
        cxo_pkg::CMD_SET_POS: begin
          cur_x = it.coord_x;
          cur_y = it.coord_y;
        end
        cxo_pkg::CMD_SET_HOT: begin
          spot_x = it.hot_x;
          spot_y = it.hot_y;
        end
        cxo_pkg::CMD_ENABLE:  shown_en = 1'b1;
        cxo_pkg::CMD_DISABLE: shown_en = 1'b0;
        cxo_pkg::CMD_HIDE:    if (hide_cnt < cxo_pkg::HIDE_MAX) hide_cnt++;
        default:              if (hide_cnt > 0) hide_cnt--;
      endcase
    endfunction

    function void check_result(logic [7:0] pix, logic hit);
      logic [7:0] e_pix;
      logic       e_hit;
      if (want_pixel.size() == 0) begin
        errors++;
        $display("%0t unexpected output transfer: pixel_out %02h in_cursor %0d",
                 $time, pix, hit);
        return;
      end
      e_pix = want_pixel.pop_front();
      e_hit = want_hit.pop_front();
      if (pix !== e_pix) begin
        errors++;
        $display("%0t pixel_out mismatch: expected %02h actual %02h", $time, e_pix, pix);
      end
      if (hit !== e_hit) begin
        errors++;
        $display("%0t in_cursor mismatch: expected %0d actual %0d", $time, e_hit, hit);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // coord_x, coord_y, pixel_in, row_index, clear_bits, set_bits, hot_x, hot_y
  logic [2:0]  s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // pixel_out
  logic        m_tuser;   // in_cursor
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  overlay_scoreboard sb;
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int cycle_cnt;

  cursor_and_xor_overlay_top #(
    .CURSOR_SIZE(BOX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it = {$urandom, $urandom, 16'($urandom)};
    return it;
  endfunction

  function automatic item_t pixel_at(int x, int y, logic [7:0] p);
    item_t it;
    it          = rand_item();
    it.coord_x  = 12'(x);
    it.coord_y  = 12'(y);
    it.pixel_in = p;
    return it;
  endfunction

  function automatic item_t row_load(logic [3:0] r, logic [15:0] clr, logic [15:0] set);
    item_t it;
    it            = rand_item();
    it.row_index  = r;
    it.clear_bits = clr;
    it.set_bits   = set;
    return it;
  endfunction

  function automatic item_t place(int x, int y);
    item_t it;
    it         = rand_item();
    it.coord_x = 12'(x);
    it.coord_y = 12'(y);
    return it;
  endfunction

  function automatic item_t hotspot(logic [5:0] hx, logic [5:0] hy);
    item_t it;
    it       = rand_item();
    it.hot_x = hx;
    it.hot_y = hy;
    return it;
  endfunction

  // pixel in or just around the current box
  function automatic item_t near_box();
    int x, y;
    x = sb.box_left() + $urandom_range(0, BOX + 5) - 3;
    y = sb.box_top() + $urandom_range(0, BOX + 5) - 3;
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    if (y < 0) y = 0;
    if (y > 4095) y = 4095;
    return pixel_at(x, y, 8'($urandom));
  endfunction

  // one input transfer, with a random gap ahead of it
  task automatic send(cxo_pkg::cmd_t c, item_t it);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= it;
    do @(posedge clk); while (!s_tready);
    sb.note_input(c, it);
  endtask

  // stop offering and wait for every expected pixel
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // write log_depth while idle, then read it back
  task automatic set_depth(logic [1:0] ld);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * cxo_pkg::REG_LOG_DEPTH);
    pwdata  <= {$urandom_range(0, 1) ? 30'($urandom) : 30'd0, ld};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.log_depth = ld;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[1:0] !== ld) begin
      sb.errors++;
      $display("%0t log_depth readback mismatch: expected %0d actual %0d",
               $time, ld, prdata[1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly pixels around the box, mixed with random commands
  task automatic random_burst(int count);
    int r, m;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 62) send(cxo_pkg::CMD_PIXEL, near_box());
      else if (r < 70) send(cxo_pkg::CMD_PIXEL, rand_item());
      else if (r < 78) send(cxo_pkg::CMD_LOAD_ROW, rand_item());
      else if (r < 82) begin
        m = $urandom_range(0, 2);
        if (m == 0) send(cxo_pkg::CMD_SET_POS, rand_item());
        else if (m == 1)
          send(cxo_pkg::CMD_SET_POS, place($urandom_range(0, 20), $urandom_range(0, 20)));
        else
          send(cxo_pkg::CMD_SET_POS,
               place($urandom_range(4075, 4095), $urandom_range(4075, 4095)));
      end
      else if (r < 86) send(cxo_pkg::CMD_SET_HOT, rand_item());
      else if (r < 90) send(cxo_pkg::CMD_ENABLE, rand_item());
      else if (r < 92) send(cxo_pkg::CMD_DISABLE, rand_item());
      else if (r < 95) send(cxo_pkg::CMD_HIDE, rand_item());
      else send(cxo_pkg::CMD_UNHIDE, rand_item());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // receiver back-pressure, with one long hold-off on request
  initial begin
    int stall_left;
    int g;
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        g = pick_gap(rx_steady);
        if (g > 0) begin
          stall_left = g - 1;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // output transfer check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    sb        = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = cxo_pkg::CMD_PIXEL;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_depth(2'd3);

    // directed: cursor off, rows never loaded, all four codes, box edges
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 0, 8'hFF));
    send(cxo_pkg::CMD_ENABLE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 0, 8'h5A));
    send(cxo_pkg::CMD_LOAD_ROW, row_load(4'd0, 16'hCCCC, 16'hAAAA));
    for (int c = 0; c < 4; c++) send(cxo_pkg::CMD_PIXEL, pixel_at(c, 0, 8'h5A));
    send(cxo_pkg::CMD_LOAD_ROW, row_load(4'd15, 16'hFFFF, 16'h0001));
    send(cxo_pkg::CMD_PIXEL, pixel_at(15, 15, 8'h00));
    send(cxo_pkg::CMD_PIXEL, pixel_at(16, 15, 8'hFF));
    // far corner, hotspot at both extremes
    send(cxo_pkg::CMD_SET_POS, place(4095, 4095));
    send(cxo_pkg::CMD_SET_HOT, hotspot(6'h30, 6'h30));
    send(cxo_pkg::CMD_PIXEL, pixel_at(4095, 4095, 8'h81));
    send(cxo_pkg::CMD_SET_HOT, hotspot(6'h10, 6'h10));
    send(cxo_pkg::CMD_PIXEL, pixel_at(4094, 4094, 8'h81));
    send(cxo_pkg::CMD_PIXEL, pixel_at(4095, 4095, 8'h81));
    // hotspot outside the usual span, box partly left of column 0
    send(cxo_pkg::CMD_SET_POS, place(5, 5));
    send(cxo_pkg::CMD_SET_HOT, hotspot(6'h1F, 6'h20));
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 40, 8'h3C));
    send(cxo_pkg::CMD_SET_HOT, hotspot(6'h08, 6'h08));
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 0, 8'h3C));
    // hide and unhide, unhide floors at zero
    send(cxo_pkg::CMD_HIDE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 0, 8'h3C));
    send(cxo_pkg::CMD_UNHIDE, rand_item());
    send(cxo_pkg::CMD_UNHIDE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 0, 8'h3C));
    send(cxo_pkg::CMD_DISABLE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(0, 0, 8'h3C));
    send(cxo_pkg::CMD_ENABLE, rand_item());
    random_burst(50);

    // 1 bit per pixel, hide count saturation and floor
    set_depth(2'd0);
    random_burst(30);
    send(cxo_pkg::CMD_ENABLE, rand_item());
    send(cxo_pkg::CMD_SET_POS, place(200, 200));
    send(cxo_pkg::CMD_SET_HOT, hotspot(6'h00, 6'h00));
    repeat (258) send(cxo_pkg::CMD_HIDE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(205, 205, 8'hFF));
    repeat (254) send(cxo_pkg::CMD_UNHIDE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(205, 205, 8'hFF));
    send(cxo_pkg::CMD_UNHIDE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(205, 205, 8'hFF));
    send(cxo_pkg::CMD_UNHIDE, rand_item());
    send(cxo_pkg::CMD_PIXEL, pixel_at(205, 205, 8'hFF));

    // 2 bits per pixel, receiver holds off while the sender keeps offering
    set_depth(2'd1);
    send(cxo_pkg::CMD_ENABLE, rand_item());
    hold_req  = 1'b1;
    tx_steady = 1'b1;
    for (int i = 0; i < 40; i++) send(cxo_pkg::CMD_PIXEL, near_box());
    tx_steady = 1'b0;
    random_burst(40);

    // 4 bits per pixel, sender pause mid-stream
    set_depth(2'd2);
    random_burst(25);
    drain();
    random_burst(25);

    set_depth(2'd3);
    random_burst(40);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== cursor_and_xor_overlay_top.f =====
rtl/cxo_pkg.sv
rtl/cursor_and_xor_overlay_top.sv
rtl/cxo_checker.sv
tb/tb_cursor_and_xor_overlay_top.sv
